// ===== hw/rtl/ees_pkg.sv =====
// Shared types and constants for the edge epoch sampler.
package ees_pkg;

    localparam int EDGE_COUNT   = 4096;
    localparam int FRAC_BITS    = 16;

    localparam int IDX_FIELD_W  = 12;
    localparam int PERIOD_W     = 32;
    localparam int EPOCH_W      = 16;
    localparam int RATE_W       = 8;
    localparam int NEG_W        = 8;

    localparam int IDX_W        = $clog2(EDGE_COUNT);
    localparam int ACC_W        = 32 + FRAC_BITS;
    localparam int DIV_W        = PERIOD_W + RATE_W;
    localparam int LOAD_STEPS   = PERIOD_W;
    localparam int VISIT_STEPS  = NEG_W;
    localparam int STEP_W       = $clog2(LOAD_STEPS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RATE_W-1:0] RATE_RESET = 8'd5;
    localparam logic [NEG_W-1:0]  NEG_SAT    = 8'hFF;

    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [DIV_W-1:0] t_div;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_VISIT
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_WB
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [IDX_W-1:0]    addr;
        logic [PERIOD_W-1:0] period;
        logic [EPOCH_W-1:0]  epoch;
    } t_cmd;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] neg_period;
        t_acc                next_due;
        t_acc                next_neg_due;
    } t_entry;

endpackage

// ===== hw/rtl/ees_if.sv =====
// Request and response channel interfaces of the edge epoch sampler.
interface ees_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [ees_pkg::IDX_FIELD_W-1:0]  edge_index;
    logic [ees_pkg::PERIOD_W-1:0]     period_value;
    logic [ees_pkg::EPOCH_W-1:0]      epoch;

    modport source (output valid, req_type, edge_index, period_value, epoch, input ready);
    modport sink   (input valid, req_type, edge_index, period_value, epoch, output ready);
endinterface

interface ees_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       sampled;
    logic [ees_pkg::NEG_W-1:0]  neg_count;

    modport source (output valid, sampled, neg_count, input ready);
    modport sink   (input valid, sampled, neg_count, output ready);
endinterface

// ===== hw/rtl/ees_front.sv =====
// Front end: takes request transfers, classifies them and queues commands.
module ees_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ees_req_if.sink        i_req,
    output logic           o_cmd_valid,
    output ees_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);

    ees_pkg::t_cmd                r_q [ees_pkg::QUEUE_DEPTH];
    logic [ees_pkg::QPTR_W-1:0]   r_wptr, n_wptr;
    logic [ees_pkg::QPTR_W-1:0]   r_rptr, n_rptr;
    logic [ees_pkg::QCNT_W-1:0]   r_count, n_count;
    ees_pkg::t_cmd                new_cmd;
    logic [31:0]                  idx_ext;
    logic                         in_range;
    logic                         push;
    logic                         pop;

    always_comb begin
        idx_ext  = 32'(i_req.edge_index);
        in_range = idx_ext < 32'(ees_pkg::EDGE_COUNT);
        if (!in_range) begin
            new_cmd.op = ees_pkg::OP_NOP;
        end else if (i_req.req_type) begin
            new_cmd.op = ees_pkg::OP_VISIT;
        end else begin
            new_cmd.op = ees_pkg::OP_LOAD;
        end
        new_cmd.addr   = idx_ext[ees_pkg::IDX_W-1:0];
        new_cmd.period = i_req.period_value;
        new_cmd.epoch  = i_req.epoch;
    end

    assign i_req.ready = (r_count != ees_pkg::QCNT_W'(ees_pkg::QUEUE_DEPTH));
    assign push        = i_req.valid & i_req.ready;
    assign pop         = i_cmd_pop & o_cmd_valid;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == ees_pkg::QPTR_W'(ees_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == ees_pkg::QPTR_W'(ees_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : r_rptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= new_cmd;
        end
    end

endmodule

// ===== hw/rtl/ees_back.sv =====
// Back end: edge table, shared radix-2 divider and response register.
module ees_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  ees_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    input  logic [ees_pkg::RATE_W-1:0]  i_neg_rate,
    ees_rsp_if.source                   o_rsp
);

    ees_pkg::t_entry              r_mem [ees_pkg::EDGE_COUNT];
    ees_pkg::t_entry              r_rd;
    ees_pkg::t_state              r_state, n_state;
    ees_pkg::t_cmd                r_cmd, n_cmd;
    ees_pkg::t_acc                r_rem, n_rem;
    ees_pkg::t_div                r_div, n_div;
    logic [ees_pkg::PERIOD_W-1:0] r_q, n_q;
    logic [ees_pkg::STEP_W-1:0]   r_step, n_step;
    logic [ees_pkg::NEG_W-1:0]    r_negc, n_negc;
    ees_pkg::t_acc                r_adv, n_adv;
    logic                         r_divided, n_divided;
    logic                         r_out_valid, n_out_valid;
    logic                         r_sampled, n_sampled;
    logic [ees_pkg::NEG_W-1:0]    r_neg_count, n_neg_count;

    logic                         mem_re;
    logic                         mem_we;
    ees_pkg::t_entry              mem_wdata;
    logic [ees_pkg::RATE_W-1:0]   rate_eff;
    ees_pkg::t_acc                ep;
    ees_pkg::t_acc                np_ext;
    ees_pkg::t_acc                np_x256;
    ees_pkg::t_acc                diff;
    logic                         div_ge;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.sampled   = r_sampled;
    assign o_rsp.neg_count = r_neg_count;

    always_comb begin
        rate_eff = (i_neg_rate == '0) ? ees_pkg::RATE_W'(1) : i_neg_rate;
        ep       = ees_pkg::t_acc'(r_cmd.epoch) << ees_pkg::FRAC_BITS;
        np_ext   = ees_pkg::t_acc'(r_rd.neg_period);
        np_x256  = np_ext << ees_pkg::NEG_W;
        diff     = ep - r_rd.next_neg_due;
        div_ge   = r_rem >= ees_pkg::t_acc'(r_div);
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_rem       = r_rem;
        n_div       = r_div;
        n_q         = r_q;
        n_step      = r_step;
        n_negc      = r_negc;
        n_adv       = r_adv;
        n_divided   = r_divided;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        n_sampled   = r_sampled;
        n_neg_count = r_neg_count;
        o_cmd_pop   = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = r_rd;

        case (r_state)
            ees_pkg::S_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    case (i_cmd.op)
                        ees_pkg::OP_LOAD: begin
                            // period / rate, one quotient bit per cycle
                            n_rem   = ees_pkg::t_acc'(i_cmd.period);
                            n_div   = ees_pkg::t_div'(rate_eff) << (ees_pkg::LOAD_STEPS - 1);
                            n_q     = '0;
                            n_step  = ees_pkg::STEP_W'(ees_pkg::LOAD_STEPS - 1);
                            n_state = ees_pkg::S_DIV;
                        end
                        ees_pkg::OP_VISIT: begin
                            mem_re  = 1'b1;
                            n_state = ees_pkg::S_CHK;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_sampled   = 1'b0;
                            n_neg_count = '0;
                        end
                    endcase
                end
            end

            ees_pkg::S_CHK: begin
                if (r_rd.next_due > ep) begin
                    n_out_valid = 1'b1;
                    n_sampled   = 1'b0;
                    n_neg_count = '0;
                    n_state     = ees_pkg::S_IDLE;
                end else begin
                    n_divided = 1'b0;
                    if (r_rd.next_neg_due > ep) begin
                        n_negc  = '0;
                        n_adv   = '0;
                        n_state = ees_pkg::S_WB;
                    end else if (diff >= np_x256) begin
                        // also covers a zero negative period
                        n_negc  = ees_pkg::NEG_SAT;
                        n_adv   = np_x256 - np_ext;
                        n_state = ees_pkg::S_WB;
                    end else begin
                        // quotient fits in NEG_W bits here
                        n_rem     = diff;
                        n_div     = ees_pkg::t_div'(r_rd.neg_period)
                                    << (ees_pkg::VISIT_STEPS - 1);
                        n_q       = '0;
                        n_step    = ees_pkg::STEP_W'(ees_pkg::VISIT_STEPS - 1);
                        n_divided = 1'b1;
                        n_state   = ees_pkg::S_DIV;
                    end
                end
            end

            ees_pkg::S_DIV: begin
                n_rem  = div_ge ? (r_rem - ees_pkg::t_acc'(r_div)) : r_rem;
                n_q    = {r_q[ees_pkg::PERIOD_W-2:0], div_ge};
                n_div  = r_div >> 1;
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_negc  = n_q[ees_pkg::NEG_W-1:0];
                    n_state = ees_pkg::S_WB;
                end
            end

            ees_pkg::S_WB: begin
                mem_we      = 1'b1;
                n_out_valid = 1'b1;
                n_state     = ees_pkg::S_IDLE;
                if (r_cmd.op == ees_pkg::OP_VISIT) begin
                    mem_wdata.period     = r_rd.period;
                    mem_wdata.neg_period = r_rd.neg_period;
                    mem_wdata.next_due   = r_rd.next_due + ees_pkg::t_acc'(r_rd.period);
                    // after a division, due + count * period equals epoch - remainder
                    mem_wdata.next_neg_due = r_divided ? (ep - r_rem)
                                                       : (r_rd.next_neg_due + r_adv);
                    n_sampled   = 1'b1;
                    n_neg_count = r_negc;
                end else begin
                    mem_wdata.period       = r_cmd.period;
                    mem_wdata.neg_period   = r_q;
                    mem_wdata.next_due     = ees_pkg::t_acc'(r_cmd.period);
                    mem_wdata.next_neg_due = ees_pkg::t_acc'(r_q);
                    n_sampled   = 1'b0;
                    n_neg_count = '0;
                end
            end

            default: begin
                n_state = ees_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ees_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_q         <= n_q;
        r_step      <= n_step;
        r_negc      <= n_negc;
        r_adv       <= n_adv;
        r_divided   <= n_divided;
        r_sampled   <= n_sampled;
        r_neg_count <= n_neg_count;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cmd.addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[i_cmd.addr];
        end
    end

endmodule

// ===== hw/rtl/edge_epoch_sampler_unit.sv =====
// Top level of the edge epoch sampler: config register, front end and back end.
//
//  port        dir  kind        carries
//  i_req       in   valid/ready req_type, edge_index, period_value, epoch
//  o_rsp       out  valid/ready sampled, neg_count
//  i_cfg_we    in   write only  i_cfg_wdata -> negative_rate (reset 5)
//
// Back end per command: load runs a 32-step radix-2 divide by negative_rate, a sampled
// visit an 8-step divide, or none when the count is 0 or saturated; an early visit or an
// out-of-range index responds without a divide. The shared divider sets the pace. Commands
// pass through a registered queue, and the next command starts only after the o_rsp transfer.
// Reset is synchronous; the edge table is not cleared and needs no sweep.
// The front keeps taking requests while the queue has room, even if o_rsp stalls.
module edge_epoch_sampler_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ees_req_if.sink                     i_req,
    ees_rsp_if.source                   o_rsp,
    input  logic                        i_cfg_we,
    input  logic [ees_pkg::RATE_W-1:0]  i_cfg_wdata
);

    logic [ees_pkg::RATE_W-1:0] r_neg_rate;
    logic                       cmd_valid;
    ees_pkg::t_cmd              cmd;
    logic                       cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_rate <= ees_pkg::RATE_RESET;
        end else if (i_cfg_we) begin
            r_neg_rate <= i_cfg_wdata;
        end
    end

    ees_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ees_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_neg_rate  (r_neg_rate),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== tb/tb_edge_epoch_sampler_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for edge_epoch_sampler_unit: predicted decisions vs. responses.
module tb_edge_epoch_sampler_unit;

    localparam bit REQ_LOAD  = 1'b0;
    localparam bit REQ_VISIT = 1'b1;

    localparam int NUM_EDGES      = 1 << ees_pkg::IDX_FIELD_W;
    localparam int POOL_SIZE      = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic [ees_pkg::PERIOD_W-1:0] ONE_EPOCH = 32'h0001_0000;

    typedef struct {
        bit                              req_type;
        logic [ees_pkg::IDX_FIELD_W-1:0] edge_index;
        logic [ees_pkg::PERIOD_W-1:0]    period_value;
        logic [ees_pkg::EPOCH_W-1:0]     epoch;
    } t_edge_req;

    typedef struct {
        logic                      sampled;
        logic [ees_pkg::NEG_W-1:0] neg_count;
    } t_edge_rsp;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [ees_pkg::RATE_W-1:0] cfg_wdata;

    ees_req_if req_ch ();
    ees_rsp_if rsp_ch ();

    edge_epoch_sampler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // predicted per-edge state
    logic [ees_pkg::PERIOD_W-1:0] period_mem     [NUM_EDGES];
    logic [ees_pkg::PERIOD_W-1:0] neg_period_mem [NUM_EDGES];
    ees_pkg::t_acc                due_mem        [NUM_EDGES];
    ees_pkg::t_acc                neg_due_mem    [NUM_EDGES];
    bit                           loaded         [NUM_EDGES];
    logic [ees_pkg::RATE_W-1:0]   rate_model = ees_pkg::RATE_RESET;

    t_edge_rsp owed_rsps[$];

    // working set of edges for the random traffic
    logic [ees_pkg::IDX_FIELD_W-1:0] pool_edge  [POOL_SIZE];
    logic [ees_pkg::EPOCH_W-1:0]     pool_clock [POOL_SIZE];
    bit                              pool_live  [POOL_SIZE];

    bit hold_rsp;
    bit req_steady;
    int fail_count;
    int n_loads, n_hits, n_misses, n_sat, n_zero;
    int n_rate_writes;
    int rate_lo = 255;
    int rate_hi = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_edge_rsp apply_edge_req(t_edge_req r);
        t_edge_rsp                  res;
        ees_pkg::t_acc              ep;
        ees_pkg::t_acc              q;
        logic [ees_pkg::RATE_W-1:0] rate;
        logic [ees_pkg::NEG_W-1:0]  cnt;
        res.sampled   = 1'b0;
        res.neg_count = '0;
        ep = ees_pkg::t_acc'(r.epoch) << ees_pkg::FRAC_BITS;
        if (r.req_type == REQ_LOAD) begin
            rate = (rate_model == '0) ? 8'd1 : rate_model;
            period_mem[r.edge_index]     = r.period_value;
            neg_period_mem[r.edge_index] = r.period_value / rate;
            due_mem[r.edge_index]        = ees_pkg::t_acc'(r.period_value);
            neg_due_mem[r.edge_index]    = ees_pkg::t_acc'(neg_period_mem[r.edge_index]);
            loaded[r.edge_index]         = 1'b1;
            n_loads++;
        end else if (due_mem[r.edge_index] > ep) begin
            n_misses++;
        end else begin
            if (neg_due_mem[r.edge_index] > ep) begin
                cnt = '0;
            end else if (neg_period_mem[r.edge_index] == '0) begin
                cnt = ees_pkg::NEG_SAT;
            end else begin
                q   = (ep - neg_due_mem[r.edge_index])
                      / ees_pkg::t_acc'(neg_period_mem[r.edge_index]);
                cnt = (q > ees_pkg::t_acc'(ees_pkg::NEG_SAT)) ? ees_pkg::NEG_SAT
                                                              : q[ees_pkg::NEG_W-1:0];
            end
            due_mem[r.edge_index] = due_mem[r.edge_index]
                                  + ees_pkg::t_acc'(period_mem[r.edge_index]);
            neg_due_mem[r.edge_index] = neg_due_mem[r.edge_index]
                                      + ees_pkg::t_acc'(cnt)
                                        * ees_pkg::t_acc'(neg_period_mem[r.edge_index]);
            res.sampled   = 1'b1;
            res.neg_count = cnt;
            n_hits++;
            if (cnt == ees_pkg::NEG_SAT) n_sat++;
            if (cnt == '0) n_zero++;
        end
        return res;
    endfunction

    // value is the period for a load and the epoch for a visit; the unused field is random
    function automatic t_edge_req mk_req(bit kind, int unsigned idx, logic [31:0] value);
        t_edge_req r;
        r.req_type   = kind;
        r.edge_index = idx[ees_pkg::IDX_FIELD_W-1:0];
        if (kind == REQ_LOAD) begin
            r.period_value = value;
            r.epoch        = ees_pkg::EPOCH_W'($urandom_range(0, 16'hFFFF));
        end else begin
            r.period_value = $urandom();
            r.epoch        = value[ees_pkg::EPOCH_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ees_pkg::PERIOD_W-1:0] random_period();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return ONE_EPOCH + $urandom_range(0, 5 * 65536);
        if (roll < 85) return ONE_EPOCH + $urandom_range(0, 511);
        if (roll < 95) return $urandom_range(ONE_EPOCH, 32'hFFFF_FFFF);
        return '1;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (req_steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called just after a rising edge; returns just after the edge of the transfer (plus gap)
    task automatic send_req(t_edge_req r, int gap);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.req_type;
        req_ch.edge_index   <= r.edge_index;
        req_ch.period_value <= r.period_value;
        req_ch.epoch        <= r.epoch;
        @(negedge i_clk);
        while (!req_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        owed_rsps.push_back(apply_edge_req(r));
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (owed_rsps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [ees_pkg::RATE_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        rate_model = v;
        n_rate_writes++;
        if (int'(v) < rate_lo) rate_lo = int'(v);
        if (int'(v) > rate_hi) rate_hi = int'(v);
    endtask

    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_edge[i]  = ees_pkg::IDX_FIELD_W'($urandom_range(0, NUM_EDGES - 1));
            pool_clock[i] = '0;
            pool_live[i]  = 1'b0;
        end
    endtask

    // mostly load-then-visit runs on the working set with epochs creeping forward
    task automatic run_traffic(int n_items, bit no_gaps);
        t_edge_req r;
        int        slot;
        int        roll;
        for (int k = 0; k < n_items; k++) begin
            if (k % 64 == 0) req_steady = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            slot = $urandom_range(0, POOL_SIZE - 1);
            if (!pool_live[slot] || roll < 12) begin
                r = mk_req(REQ_LOAD, pool_edge[slot], random_period());
                pool_live[slot]  = 1'b1;
                pool_clock[slot] = '0;
            end else if (roll < 17) begin
                r = mk_req(REQ_VISIT, $urandom_range(0, NUM_EDGES - 1),
                           $urandom_range(0, 16'hFFFF));
                // never visit an entry that holds nothing yet
                if (!loaded[r.edge_index]) r = mk_req(REQ_LOAD, r.edge_index, random_period());
            end else if (roll < 22) begin
                r = mk_req(REQ_VISIT, pool_edge[slot], $urandom_range(0, 16'hFFFF));
            end else begin
                if (pool_clock[slot] < 16'hFFF0)
                    pool_clock[slot] += ees_pkg::EPOCH_W'($urandom_range(0, 3));
                r = mk_req(REQ_VISIT, pool_edge[slot], pool_clock[slot]);
            end
            send_req(r, no_gaps ? 0 : pick_gap());
        end
    endtask

    task automatic test_directed_corners();
        // reset rate of 5 first
        send_req(mk_req(REQ_LOAD, 0, ONE_EPOCH), 0);
        send_req(mk_req(REQ_LOAD, 4095, 32'hFFFF_FFFF), 1);
        send_req(mk_req(REQ_VISIT, 0, 0), 0);
        send_req(mk_req(REQ_VISIT, 0, 1), 0);
        send_req(mk_req(REQ_VISIT, 0, 1), 2);
        send_req(mk_req(REQ_VISIT, 4095, 16'hFFFF), 0);
        send_req(mk_req(REQ_VISIT, 0, 16'hFFFF), 0);
        // due again but negative due far ahead of the epoch
        send_req(mk_req(REQ_VISIT, 0, 3), 1);
        send_req(mk_req(REQ_LOAD, 4095, 32'hFFFF_0000), 0);
        send_req(mk_req(REQ_VISIT, 4095, 16'hFFFF), 0);
        send_req(mk_req(REQ_VISIT, 4095, 16'hFFFF), 0);
        send_req(mk_req(REQ_LOAD, 12'hAAA, 32'h5555_5555), 0);
        send_req(mk_req(REQ_LOAD, 12'h555, 32'h0002_8000), 0);
        send_req(mk_req(REQ_VISIT, 12'h555, 2), 0);
        send_req(mk_req(REQ_VISIT, 12'h555, 3), 0);
        send_req(mk_req(REQ_VISIT, 12'h555, 5), 0);
        send_req(mk_req(REQ_VISIT, 12'hAAA, 16'h5555), 0);
        send_req(mk_req(REQ_VISIT, 12'hAAA, 16'h5556), 3);
        write_rate(8'd1);
        send_req(mk_req(REQ_LOAD, 1, ONE_EPOCH), 0);
        send_req(mk_req(REQ_VISIT, 1, 1), 0);
        send_req(mk_req(REQ_VISIT, 1, 9), 0);
        write_rate(8'd255);
        send_req(mk_req(REQ_LOAD, 2, ONE_EPOCH), 0);
        send_req(mk_req(REQ_VISIT, 2, 1), 0);
        send_req(mk_req(REQ_VISIT, 2, 2), 0);
    endtask

    task automatic test_rate_sweep();
        logic [ees_pkg::RATE_W-1:0] rates [6];
        rates = '{8'd1, 8'd255, 8'd2, 8'd5, 8'd128, 8'd0};
        rates[5] = ees_pkg::RATE_W'($urandom_range(1, 255));
        foreach (rates[i]) begin
            write_rate(rates[i]);
            refresh_pool();
            run_traffic(150, 1'b0);
        end
    endtask

    // response side stalls for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        settle();
        refresh_pool();
        hold_rsp = 1'b1;
        run_traffic(24, 1'b1);
        while (hold_rsp) @(posedge i_clk);
    endtask

    task automatic test_random_mix();
        repeat (4) begin
            write_rate(ees_pkg::RATE_W'($urandom_range(1, 255)));
            refresh_pool();
            run_traffic(160, 1'b0);
        end
    endtask

    initial begin : rsp_sink
        int stall;
        int roll;
        bit steady;
        steady = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) steady = ~steady;
            if (hold_rsp) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_rsp = 1'b0;
            end else if (steady) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 65) begin
                    rsp_ch.ready <= 1'b1;
                end else begin
                    rsp_ch.ready <= 1'b0;
                    stall = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                    repeat (stall - 1) @(posedge i_clk);
                end
            end
        end
    end

    // a transfer happens at the next rising edge when valid and ready are high here
    always @(negedge i_clk) begin : rsp_check
        t_edge_rsp want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            if (owed_rsps.size() == 0) begin
                $error("response with nothing outstanding: sampled=%0b neg_count=%0d",
                       rsp_ch.sampled, rsp_ch.neg_count);
                fail_count++;
            end else begin
                want = owed_rsps.pop_front();
                if (rsp_ch.sampled !== want.sampled) begin
                    $error("sampled: expected %0b, actual %0b", want.sampled, rsp_ch.sampled);
                    fail_count++;
                end
                if (rsp_ch.neg_count !== want.neg_count) begin
                    $error("neg_count: expected %0d, actual %0d",
                           want.neg_count, rsp_ch.neg_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("edge_epoch_sampler_unit verification failed");
        $finish;
    end

    initial begin : main_seq
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= 1'b0;
        req_ch.edge_index   <= '0;
        req_ch.period_value <= '0;
        req_ch.epoch        <= '0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        i_rst_n             <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_rate_sweep();
        test_output_backpressure();
        test_random_mix();

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d loads, %0d due visits (%0d saturated, %0d with no negatives),",
                 n_loads, n_hits, n_sat, n_zero);
        $display("%0d early visits; rate written %0d times, %0d to %0d; %0d-cycle output stall",
                 n_misses, n_rate_writes, rate_lo, rate_hi, HOLD_CYCLES);
        if (fail_count == 0)
            $display("edge_epoch_sampler_unit verification clean");
        else
            $display("edge_epoch_sampler_unit verification failed");
        $finish;
    end

endmodule
